@@ hw/rtl/efi_pkg.sv @@
// Package for the escape-time fractal iteration block.
// Holds widths, fixed-point constants, register indexes, payload and config types.
// No dependencies.
package efi_pkg;

	localparam int FRAC_BITS = 20;
	localparam int MAX_POWER = 8;

	localparam int DATA_W  = 32;
	localparam int CNT_W   = 16;
	localparam int PWR_W   = 4;
	localparam int ADDR_W  = 5;
	localparam int MUL_W   = 36;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int SH_W    = PROD_W - FRAC_BITS;
	localparam int SUM_W   = SH_W + 1;
	localparam int K_W     = $clog2(MAX_POWER + 1);

	// register indexes (word address)
	localparam logic [2:0] REG_JULIA_MODE = 3'd0;
	localparam logic [2:0] REG_MAX_ITER   = 3'd1;
	localparam logic [2:0] REG_POWER      = 3'd2;
	localparam logic [2:0] REG_CONST_RE   = 3'd3;
	localparam logic [2:0] REG_CONST_IM   = 3'd4;

	localparam logic [CNT_W-1:0] MAX_ITER_RST = CNT_W'(100);
	localparam logic [PWR_W-1:0] POWER_RST    = PWR_W'(2);

	// fixed-point constants
	localparam logic signed [DATA_W-1:0] TWO_FX  = DATA_W'(64'sd2 <<< FRAC_BITS);
	localparam logic signed [DATA_W-1:0] ONE_FX  = DATA_W'(64'sd1 <<< FRAC_BITS);
	localparam logic signed [DATA_W-1:0] QUARTER_FX = DATA_W'(64'sd1 <<< (FRAC_BITS - 2));
	localparam logic [PROD_W:0] BULB_LIM   = (PROD_W+1)'(1) << (2 * FRAC_BITS - 4);
	localparam logic [PROD_W:0] ESCAPE_LIM = (PROD_W+1)'(4) << (2 * FRAC_BITS);

	typedef struct packed {
		logic signed [DATA_W-1:0] point_re;
		logic signed [DATA_W-1:0] point_im;
	} point_t;

	typedef struct packed {
		logic             inside_res;
		logic [CNT_W-1:0] escape_count;
		logic             by_shortcut;
	} result_t;

	typedef struct packed {
		logic                     julia_mode;
		logic [CNT_W-1:0]         max_iterations;
		logic [PWR_W-1:0]         power;
		logic signed [DATA_W-1:0] julia_const_re;
		logic signed [DATA_W-1:0] julia_const_im;
	} cfg_t;

	// saturate a wide signed sum to 32 bits
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(64'sd2147483647);
		lo = -SUM_W'(64'sd2147483648);
		if (v > hi) return DATA_W'(hi);
		if (v < lo) return DATA_W'(lo);
		return v[DATA_W-1:0];
	endfunction

endpackage

@@ hw/rtl/escape_time_fractal_iteration.sv @@
// Top level of the escape-time fractal iteration block: sequencer around one
// shared multiplier. Depends on efi_pkg, efi_mul and efi_cfg.
//
// Usage:
//  - point channel (valid/ready) carries one complex point, Q12.20 signed.
//    point_ready is high only while the sequencer is idle; one transfer
//    starts one item.
//  - result channel (valid/ready) carries inside flag, escape index and the
//    shortcut flag. The result sits in an output register, so the next point
//    can be taken while the receiver stalls; if a second result is done
//    before the first is taken, the sequencer waits in its final state.
//  - APB port writes the five registers at byte addresses 0..16; pready is
//    tied high. Write only while idle.
// Sequence: each complex multiply issues four partial products on the shared
//  multiplier; one iteration does p-1 complex multiplies (p the clamped
//  power), then adds c, then runs the |z|^2 escape test. For Mandelbrot
//  at p=2 with the point inside |re|,|im| < 2, a shortcut test runs first;
//  a bulb hit ends the item early, else the cardioid test follows.
// Reset: arst_n clears the sequencer, the result valid flag and the config
//  registers to julia_mode 0, max_iterations 100, power 2, constant 0.
module escape_time_fractal_iteration (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          point_valid,
	output logic                          point_ready,
	input  efi_pkg::point_t               point,
	output logic                          result_valid,
	input  logic                          result_ready,
	output efi_pkg::result_t              result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [efi_pkg::ADDR_W-1:0]    paddr,
	input  logic [efi_pkg::DATA_W-1:0]    pwdata,
	output logic [efi_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	localparam int MW = efi_pkg::MUL_W;
	localparam int PW = efi_pkg::PROD_W;
	localparam int DW = efi_pkg::DATA_W;
	localparam int SW = efi_pkg::SUM_W;
	localparam int KW = efi_pkg::K_W;
	localparam int F  = efi_pkg::FRAC_BITS;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SC, ST_MUL, ST_ADD, ST_SQ, ST_DONE
	} state_t;

	efi_pkg::cfg_t cfg;

	efi_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	state_t state_q;
	logic [2:0] ph_q;
	logic [KW-1:0] k_q;
	logic [efi_pkg::CNT_W-1:0] iter_q;

	logic signed [DW-1:0] x_q, y_q, zr_q, zi_q, tr_q, ti_q;
	logic signed [SW-1:0] acc_re_q;
	logic signed [PW-1:0] y2_q, sq_q;
	logic signed [MW-1:0] a_q, qf_q;

	efi_pkg::result_t res_q;   // pending result
	efi_pkg::result_t result_q;
	logic result_valid_q;

	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod_q;

	efi_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_q(prod_q));

	// clamped power and multiply count
	logic [KW-1:0] pe, nmul;
	always_comb begin
		if (cfg.power < efi_pkg::PWR_W'(2))
			pe = KW'(2);
		else if (KW'(cfg.power) > KW'(efi_pkg::MAX_POWER))
			pe = KW'(efi_pkg::MAX_POWER);
		else
			pe = KW'(cfg.power);
		nmul = pe - KW'(1);
	end

	// Julia constant or the point itself
	logic signed [DW-1:0] cr, ci;
	assign cr = cfg.julia_mode ? cfg.julia_const_re : x_q;
	assign ci = cfg.julia_mode ? cfg.julia_const_im : y_q;

	// floored product (arithmetic shift floors)
	logic signed [SW-1:0] pf;
	assign pf = SW'(prod_q >>> F);

	logic in_dom;
	assign in_dom = (point.point_re > -efi_pkg::TWO_FX) && (point.point_re < efi_pkg::TWO_FX) &&
		(point.point_im > -efi_pkg::TWO_FX) && (point.point_im < efi_pkg::TWO_FX);

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SC: begin
				case (ph_q)
					3'd0: begin mul_a = MW'(y_q); mul_b = MW'(y_q); end
					3'd1: begin
						mul_a = MW'(x_q) + MW'(efi_pkg::ONE_FX);
						mul_b = MW'(x_q) + MW'(efi_pkg::ONE_FX);
					end
					3'd2: begin mul_a = a_q; mul_b = a_q; end
					3'd4: begin mul_a = qf_q; mul_b = qf_q + a_q; end
					default: ;
				endcase
			end
			ST_MUL: begin
				case (ph_q)
					3'd0: begin mul_a = MW'(tr_q); mul_b = MW'(zr_q); end
					3'd1: begin mul_a = MW'(ti_q); mul_b = MW'(zi_q); end
					3'd2: begin mul_a = MW'(tr_q); mul_b = MW'(zi_q); end
					3'd3: begin mul_a = MW'(ti_q); mul_b = MW'(zr_q); end
					default: ;
				endcase
			end
			ST_SQ: begin
				case (ph_q)
					3'd0: begin mul_a = MW'(zr_q); mul_b = MW'(zr_q); end
					3'd1: begin mul_a = MW'(zi_q); mul_b = MW'(zi_q); end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	logic [PW:0] bulb_sum, esc_sum;
	logic signed [PW-1:0] q_sum;
	assign bulb_sum = (PW+1)'(unsigned'(prod_q)) + (PW+1)'(unsigned'(y2_q));
	assign esc_sum  = (PW+1)'(unsigned'(sq_q)) + (PW+1)'(unsigned'(prod_q));
	assign q_sum    = prod_q + y2_q;

	logic out_free;
	assign out_free = !result_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			ph_q           <= '0;
			k_q            <= '0;
			iter_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			// a load in ST_DONE takes priority over the drain
			if (result_valid_q && result_ready && state_q != ST_DONE)
				result_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (point_valid) begin
						x_q    <= point.point_re;
						y_q    <= point.point_im;
						zr_q   <= point.point_re;
						zi_q   <= point.point_im;
						tr_q   <= point.point_re;
						ti_q   <= point.point_im;
						a_q    <= MW'(point.point_re) - MW'(efi_pkg::QUARTER_FX);
						k_q    <= KW'(1);
						iter_q <= '0;
						ph_q   <= '0;
						res_q  <= '{inside_res: 1'b1, escape_count: '0, by_shortcut: 1'b0};
						if (!cfg.julia_mode && pe == KW'(2) && in_dom)
							state_q <= ST_SC;
						else if (cfg.max_iterations == '0)
							state_q <= ST_DONE;
						else
							state_q <= ST_MUL;
					end
				end
				ST_SC: begin
					ph_q <= ph_q + 3'd1;
					case (ph_q)
						3'd1: y2_q <= prod_q;
						3'd2: begin
							if (bulb_sum <= efi_pkg::BULB_LIM) begin
								res_q.by_shortcut <= 1'b1;
								state_q <= ST_DONE;
							end
						end
						3'd3: qf_q <= MW'(q_sum >>> F);
						3'd5: begin
							ph_q <= '0;
							if (prod_q <= (y2_q >>> 2)) begin
								res_q.by_shortcut <= 1'b1;
								state_q <= ST_DONE;
							end else if (cfg.max_iterations == '0)
								state_q <= ST_DONE;
							else
								state_q <= ST_MUL;
						end
						default: ;
					endcase
				end
				ST_MUL: begin
					ph_q <= ph_q + 3'd1;
					case (ph_q)
						3'd1: acc_re_q <= pf;
						3'd2: tr_q <= efi_pkg::sat32(acc_re_q - pf);
						3'd3: acc_re_q <= pf;
						3'd4: begin
							ti_q <= efi_pkg::sat32(acc_re_q + pf);
							ph_q <= '0;
							if (k_q == nmul)
								state_q <= ST_ADD;
							else
								k_q <= k_q + KW'(1);
						end
						default: ;
					endcase
				end
				ST_ADD: begin
					zr_q    <= efi_pkg::sat32(SW'(tr_q) + SW'(cr));
					zi_q    <= efi_pkg::sat32(SW'(ti_q) + SW'(ci));
					ph_q    <= '0;
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					ph_q <= ph_q + 3'd1;
					if (ph_q == 3'd1)
						sq_q <= prod_q;
					if (ph_q == 3'd2) begin
						ph_q <= '0;
						if (esc_sum > efi_pkg::ESCAPE_LIM) begin
							res_q.inside_res   <= 1'b0;
							res_q.escape_count <= iter_q;
							state_q <= ST_DONE;
						end else if (iter_q + efi_pkg::CNT_W'(1) == cfg.max_iterations) begin
							state_q <= ST_DONE;
						end else begin
							iter_q  <= iter_q + efi_pkg::CNT_W'(1);
							tr_q    <= zr_q;
							ti_q    <= zi_q;
							k_q     <= KW'(1);
							state_q <= ST_MUL;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						result_q       <= res_q;
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign point_ready  = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		point_ready |-> !(state_q == ST_MUL || state_q == ST_SQ || state_q == ST_SC))
		else $error("point_ready high while busy");
	a_shortcut_inside: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (!result.by_shortcut || result.inside_res))
		else $error("shortcut result not marked inside");
	a_inside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.inside_res) |-> (result.escape_count == '0))
		else $error("inside result with nonzero count");
	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (iter_q < cfg.max_iterations))
		else $error("iteration past limit");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && result_valid_q && !result_ready) |=> (state_q == ST_DONE))
		else $error("result overwritten while stalled");

endmodule

@@ hw/rtl/efi_mul.sv @@
// Shared signed multiplier with registered product.
// Depends on efi_pkg for operand widths.
module efi_mul (
	input  logic                                  clk,
	input  logic signed [efi_pkg::MUL_W-1:0]      a,
	input  logic signed [efi_pkg::MUL_W-1:0]      b,
	output logic signed [efi_pkg::PROD_W-1:0]     prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

@@ hw/rtl/efi_cfg.sv @@
// APB-style configuration registers of the fractal iteration block.
// Depends on efi_pkg for register indexes and cfg_t.
module efi_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [efi_pkg::ADDR_W-1:0]    paddr,
	input  logic [efi_pkg::DATA_W-1:0]    pwdata,
	output logic [efi_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	output efi_pkg::cfg_t                 cfg
);

	efi_pkg::cfg_t cfg_q;
	logic [2:0]    idx;
	logic          wr;

	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.julia_mode     <= 1'b0;
			cfg_q.max_iterations <= efi_pkg::MAX_ITER_RST;
			cfg_q.power          <= efi_pkg::POWER_RST;
			cfg_q.julia_const_re <= '0;
			cfg_q.julia_const_im <= '0;
		end else if (wr) begin
			unique case (idx)
				efi_pkg::REG_JULIA_MODE: cfg_q.julia_mode     <= pwdata[0];
				efi_pkg::REG_MAX_ITER:   cfg_q.max_iterations <= pwdata[efi_pkg::CNT_W-1:0];
				efi_pkg::REG_POWER:      cfg_q.power          <= pwdata[efi_pkg::PWR_W-1:0];
				efi_pkg::REG_CONST_RE:   cfg_q.julia_const_re <= pwdata;
				efi_pkg::REG_CONST_IM:   cfg_q.julia_const_im <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			efi_pkg::REG_JULIA_MODE: prdata = {{(efi_pkg::DATA_W-1){1'b0}}, cfg_q.julia_mode};
			efi_pkg::REG_MAX_ITER:
				prdata = {{(efi_pkg::DATA_W-efi_pkg::CNT_W){1'b0}}, cfg_q.max_iterations};
			efi_pkg::REG_POWER:
				prdata = {{(efi_pkg::DATA_W-efi_pkg::PWR_W){1'b0}}, cfg_q.power};
			efi_pkg::REG_CONST_RE:   prdata = cfg_q.julia_const_re;
			efi_pkg::REG_CONST_IM:   prdata = cfg_q.julia_const_im;
			default:                 prdata = '0;
		endcase
	end

endmodule
